@@ rtl/wet_pkg.sv @@
// Shared constants, types and the control store for the weighted edge table.
// Used by the channel interfaces, the sequencer and the top level; no dependencies.
package wet_pkg;

    // Graph geometry.
    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 8;
    localparam int SLOT_TOTAL   = MAX_VERTICES * MAX_EDGES;
    localparam int SLOT_W       = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int EDGE_W       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    // Field widths of the request and response items.
    localparam int ACTION_W = 3;
    localparam int VTX_W    = 4;
    localparam int WEIGHT_W = 32;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;

    localparam logic [EDGE_W-1:0] EDGE_LAST = EDGE_W'(MAX_EDGES - 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_VERTEX   = 3'd0,
        ACT_ADD_EDGE     = 3'd1,
        ACT_REMOVE_EDGE  = 3'd2,
        ACT_LOOKUP_EDGE  = 3'd3,
        ACT_CHECK_VERTEX = 3'd4,
        ACT_READ_COUNT   = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_SOURCE = 3'd1,
        ST_SLOTS_FULL = 3'd2,
        ST_ABSENT     = 3'd3,
        ST_GRAPH_FULL = 3'd4
    } t_status;

    // Program steps of the sequencer. MISS must directly follow SCAN.
    typedef enum logic [2:0] {
        STEP_IDLE       = 3'd0,
        STEP_DISPATCH   = 3'd1,
        STEP_SCAN       = 3'd2,
        STEP_MISS       = 3'd3,
        STEP_HIT        = 3'd4,
        STEP_ADD_VERTEX = 3'd5,
        STEP_DONE       = 3'd6
    } t_step;

    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_IN       = 3'd1,
        COND_OUT      = 3'd2,
        COND_DISPATCH = 3'd3,
        COND_SCAN     = 3'd4
    } t_cond;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_LATCH      = 3'd1,
        OP_CLASSIFY   = 3'd2,
        OP_SCAN       = 3'd3,
        OP_MISS       = 3'd4,
        OP_HIT        = 3'd5,
        OP_ADD_VERTEX = 3'd6,
        OP_EMIT       = 3'd7
    } t_op;

    // One control word: datapath operation, jump condition, jump target.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Status flags from the datapath that steer the sequencer.
    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic go_scan;
        logic go_add;
        logic scan_hit;
        logic scan_done;
    } t_seq_flags;

    // One entry of the slot memory.
    typedef struct packed {
        logic [VTX_W-1:0]           dest;
        logic signed [WEIGHT_W-1:0] weight;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        case (step)
            STEP_IDLE:       w = '{op: OP_LATCH,      cond: COND_IN,       target: STEP_DISPATCH};
            STEP_DISPATCH:   w = '{op: OP_CLASSIFY,   cond: COND_DISPATCH, target: STEP_DONE};
            STEP_SCAN:       w = '{op: OP_SCAN,       cond: COND_SCAN,     target: STEP_HIT};
            STEP_MISS:       w = '{op: OP_MISS,       cond: COND_ALWAYS,   target: STEP_DONE};
            STEP_HIT:        w = '{op: OP_HIT,        cond: COND_ALWAYS,   target: STEP_DONE};
            STEP_ADD_VERTEX: w = '{op: OP_ADD_VERTEX, cond: COND_ALWAYS,   target: STEP_DONE};
            STEP_DONE:       w = '{op: OP_EMIT,       cond: COND_OUT,      target: STEP_IDLE};
            default:         w = '{op: OP_NONE,       cond: COND_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Slot memory address of edge slot k of vertex v.
    function automatic logic [SLOT_W-1:0] slot_addr(input logic [VTX_W-1:0] v,
                                                   input logic [EDGE_W-1:0] k);
        return SLOT_W'(int'(v) * MAX_EDGES + int'(k));
    endfunction

endpackage

@@ rtl/wet_if.sv @@
// Request and response channel interfaces of the weighted edge table.
// Depends on wet_pkg for the field widths.
interface wet_in_if;
    import wet_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [VTX_W-1:0]           source_vertex;
    logic [VTX_W-1:0]           dest_vertex;
    logic signed [WEIGHT_W-1:0] edge_weight;

    modport source(output valid, action, source_vertex, dest_vertex, edge_weight,
                   input ready);
    modport sink(input valid, action, source_vertex, dest_vertex, edge_weight,
                 output ready);
endinterface

interface wet_out_if;
    import wet_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic signed [WEIGHT_W-1:0] weight_out;
    logic [CNT_W-1:0]           vertex_value;

    modport source(output valid, status, found, weight_out, vertex_value,
                   input ready);
    modport sink(input valid, status, found, weight_out, vertex_value,
                 output ready);
endinterface

@@ rtl/wet_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module wet_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/wet_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on wet_pkg for the step, condition and control word types.
module wet_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wet_pkg::t_seq_flags i_flags,
    output wet_pkg::t_uword     o_uword
);
    import wet_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;

    assign uw = ucode_rom(r_step);

    // Next step.
    always_comb begin
        n_step = r_step;
        case (uw.cond)
            COND_ALWAYS: begin
                n_step = uw.target;
            end
            COND_IN: begin
                if (i_flags.in_fire) n_step = uw.target;
            end
            COND_OUT: begin
                if (i_flags.out_free) n_step = uw.target;
            end
            COND_DISPATCH: begin
                if (i_flags.go_scan) begin
                    n_step = STEP_SCAN;
                end else if (i_flags.go_add) begin
                    n_step = STEP_ADD_VERTEX;
                end else begin
                    n_step = uw.target;
                end
            end
            COND_SCAN: begin
                // A hit wins; a finished scan falls through to the next step.
                if (i_flags.scan_hit) begin
                    n_step = uw.target;
                end else if (i_flags.scan_done) begin
                    n_step = t_step'(r_step + 3'd1);
                end
            end
            default: begin
                n_step = STEP_IDLE;
            end
        endcase
    end

    // Control word output.
    always_comb begin
        o_uword = uw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // The scan step is only left through a hit or the last slot compare.
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_SCAN && !i_flags.scan_hit && !i_flags.scan_done)
        |=> r_step == STEP_SCAN)
        else $error("scan left without hit or end of slot list");

    // The miss step is reached only from a scan that ran out of slots.
    a_miss_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_MISS) |-> ($past(r_step) == STEP_SCAN && $past(i_flags.scan_done)))
        else $error("miss step entered without a completed scan");

    // The step counter stays put in the done step while the result is blocked.
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_DONE && !i_flags.out_free) |=> r_step == STEP_DONE)
        else $error("result step left while the output register was occupied");
endmodule

@@ rtl/weighted_edge_table.sv @@
// Weighted edge table: a bounded directed weighted graph store driven by a microcode sequencer.
// Depends on wet_pkg, wet_if (wet_in_if, wet_out_if), wet_ram and wet_seq.

// This block keeps a directed graph of up to MAX_VERTICES vertices, each with
// MAX_EDGES edge slots, and answers one request with exactly one response. A
// request transfer is accepted only while the sequencer sits in its idle step;
// the response sits in an output register, so the next request is accepted
// while an earlier response still waits to be taken. After the idle step, add
// vertex passes through the dispatch, add vertex and done steps, while check
// vertex, read count and bad source go from dispatch straight to done. Edge
// actions (add or update, remove, look up) go through dispatch, scan, hit or
// miss and done; the scan reads the source vertex's slots through the single
// read port of the slot memory, one slot per cycle, until a hit or the last
// slot. Slot valid bits live in flip-flops that reset clears at once, so there
// is no clearing pass; read data from the destination and weight memory is
// used only where a valid bit is set.
module weighted_edge_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wet_in_if.sink     i_req,
    wet_out_if.source  o_rsp
);
    import wet_pkg::*;

    // Sequencer interface.
    t_uword     uw;
    t_seq_flags flags;

    // Latched request.
    logic [ACTION_W-1:0]        r_action, n_action;
    logic [VTX_W-1:0]           r_src, n_src;
    logic [VTX_W-1:0]           r_dst, n_dst;
    logic signed [WEIGHT_W-1:0] r_wt, n_wt;

    // Result being built.
    t_status                    r_status, n_status;
    logic                       r_found, n_found;
    logic signed [WEIGHT_W-1:0] r_wout, n_wout;
    logic [CNT_W-1:0]           r_vval, n_vval;

    // Graph state.
    logic [CNT_W-1:0]      r_vertex_count, n_vertex_count;
    logic [SLOT_TOTAL-1:0] r_slot_valid, n_slot_valid;

    // Slot scan pipeline: one read issued and one compare done per cycle.
    logic [EDGE_W-1:0] r_rd_k, n_rd_k;
    logic              r_rd_more, n_rd_more;
    logic [EDGE_W-1:0] r_cmp_k, n_cmp_k;
    logic              r_pend, n_pend;
    logic [EDGE_W-1:0] r_hit_k, n_hit_k;

    // Output register.
    logic                       r_out_valid, n_out_valid;
    t_status                    r_out_status, n_out_status;
    logic                       r_out_found, n_out_found;
    logic signed [WEIGHT_W-1:0] r_out_wout, n_out_wout;
    logic [CNT_W-1:0]           r_out_vval, n_out_vval;

    // Slot memory ports.
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_slot_word        ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    t_slot_word        ram_rdata;

    // Helpers.
    t_action           act;
    logic              src_ok;
    logic              in_fire;
    logic              out_free;
    logic              scan_hit;
    logic              scan_done;
    logic              free_ok;
    logic [EDGE_W-1:0] free_k;
    logic              go_scan;
    logic              go_add;

    wet_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    wet_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (SLOT_TOTAL)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign act      = t_action'(r_action);
    assign src_ok   = CNT_W'(r_src) < r_vertex_count;
    assign in_fire  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // The compare looks at the slot whose read data has just come back.
    assign scan_hit  = (uw.op == OP_SCAN) && r_pend &&
                       r_slot_valid[slot_addr(r_src, r_cmp_k)] &&
                       (ram_rdata.dest == r_dst);
    assign scan_done = (uw.op == OP_SCAN) && r_pend && (r_cmp_k == EDGE_LAST);

    // Lowest free slot of the source vertex, taken from the valid bits.
    always_comb begin
        free_ok = 1'b0;
        free_k  = '0;
        for (int k = 0; k < MAX_EDGES; k++) begin
            if (!free_ok && !r_slot_valid[slot_addr(r_src, EDGE_W'(k))]) begin
                free_ok = 1'b1;
                free_k  = EDGE_W'(k);
            end
        end
    end

    assign flags = '{in_fire:   in_fire,
                     out_free:  out_free,
                     go_scan:   go_scan,
                     go_add:    go_add,
                     scan_hit:  scan_hit,
                     scan_done: scan_done};

    assign i_req.ready        = (uw.op == OP_LATCH);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.weight_out   = r_out_wout;
    assign o_rsp.vertex_value = r_out_vval;

    // Datapath: each control word operation selects what this cycle does.
    always_comb begin
        n_action       = r_action;
        n_src          = r_src;
        n_dst          = r_dst;
        n_wt           = r_wt;
        n_status       = r_status;
        n_found        = r_found;
        n_wout         = r_wout;
        n_vval         = r_vval;
        n_vertex_count = r_vertex_count;
        n_slot_valid   = r_slot_valid;
        n_rd_k         = r_rd_k;
        n_rd_more      = r_rd_more;
        n_cmp_k        = r_cmp_k;
        n_pend         = r_pend;
        n_hit_k        = r_hit_k;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_found    = r_out_found;
        n_out_wout     = r_out_wout;
        n_out_vval     = r_out_vval;
        ram_we         = 1'b0;
        ram_waddr      = slot_addr(r_src, r_hit_k);
        ram_wdata      = '{dest: r_dst, weight: r_wt};
        ram_re         = 1'b0;
        ram_raddr      = slot_addr(r_src, r_rd_k);
        go_scan        = 1'b0;
        go_add         = 1'b0;

        // The output register drains whenever the sink takes the response.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (uw.op)
            OP_LATCH: begin
                if (in_fire) begin
                    n_action = i_req.action;
                    n_src    = i_req.source_vertex;
                    n_dst    = i_req.dest_vertex;
                    n_wt     = i_req.edge_weight;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_wout   = '0;
                    n_vval   = '0;
                end
            end
            OP_CLASSIFY: begin
                // Slot zero is read here so the scan compares from its first cycle.
                ram_re    = 1'b1;
                ram_raddr = slot_addr(r_src, '0);
                n_cmp_k   = '0;
                n_pend    = 1'b1;
                n_rd_more = (MAX_EDGES > 1);
                n_rd_k    = EDGE_W'(1);
                case (act)
                    ACT_ADD_EDGE, ACT_REMOVE_EDGE, ACT_LOOKUP_EDGE: begin
                        if (src_ok) begin
                            go_scan = 1'b1;
                        end else begin
                            n_status = ST_BAD_SOURCE;
                        end
                    end
                    ACT_ADD_VERTEX: begin
                        go_add = 1'b1;
                    end
                    ACT_CHECK_VERTEX: begin
                        n_found = src_ok;
                    end
                    ACT_READ_COUNT: begin
                        n_vval = r_vertex_count;
                    end
                    default: begin
                    end
                endcase
            end
            OP_SCAN: begin
                if (r_rd_more) begin
                    ram_re    = 1'b1;
                    n_cmp_k   = r_rd_k;
                    n_pend    = 1'b1;
                    n_rd_more = (r_rd_k != EDGE_LAST);
                    n_rd_k    = r_rd_k + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (scan_hit) begin
                    n_hit_k = r_cmp_k;
                    if (act == ACT_LOOKUP_EDGE) begin
                        n_found = 1'b1;
                        n_wout  = ram_rdata.weight;
                    end
                end
            end
            OP_HIT: begin
                case (act)
                    ACT_ADD_EDGE: begin
                        ram_we = 1'b1;
                    end
                    ACT_REMOVE_EDGE: begin
                        n_slot_valid[slot_addr(r_src, r_hit_k)] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            OP_MISS: begin
                case (act)
                    ACT_ADD_EDGE: begin
                        if (free_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_addr(r_src, free_k);
                            n_slot_valid[slot_addr(r_src, free_k)] = 1'b1;
                        end else begin
                            n_status = ST_SLOTS_FULL;
                        end
                    end
                    ACT_REMOVE_EDGE: begin
                        n_status = ST_ABSENT;
                    end
                    default: begin
                    end
                endcase
            end
            OP_ADD_VERTEX: begin
                if (r_vertex_count >= CNT_W'(MAX_VERTICES)) begin
                    n_status = ST_GRAPH_FULL;
                end else begin
                    n_vval         = r_vertex_count;
                    n_vertex_count = r_vertex_count + 1'b1;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_wout   = r_wout;
                    n_out_vval   = r_vval;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_slot_valid   <= '0;
            r_out_valid    <= 1'b0;
            r_pend         <= 1'b0;
            r_rd_more      <= 1'b0;
        end else begin
            r_vertex_count <= n_vertex_count;
            r_slot_valid   <= n_slot_valid;
            r_out_valid    <= n_out_valid;
            r_pend         <= n_pend;
            r_rd_more      <= n_rd_more;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_wt         <= n_wt;
        r_status     <= n_status;
        r_found      <= n_found;
        r_wout       <= n_wout;
        r_vval       <= n_vval;
        r_rd_k       <= n_rd_k;
        r_cmp_k      <= n_cmp_k;
        r_hit_k      <= n_hit_k;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_wout   <= n_out_wout;
        r_out_vval   <= n_out_vval;
    end

    // Requests are taken one at a time: never two transfers on adjacent edges.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !(i_req.valid && i_req.ready))
        else $error("request accepted while the previous one was still in work");

    // A successful remove clears exactly one valid bit.
    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_HIT && act == ACT_REMOVE_EDGE)
        |=> $countones(r_slot_valid) == $countones($past(r_slot_valid)) - 1)
        else $error("edge removal did not clear exactly one slot");

    // The slot memory is written only by the hit and miss steps.
    a_write_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (uw.op == OP_HIT || uw.op == OP_MISS))
        else $error("slot memory written outside an edge update");

    // A new response is loaded only from the emit step.
    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(uw.op == OP_EMIT))
        else $error("response offered without passing the emit step");

    // The vertex count never passes the graph size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vertex_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond the graph size");
endmodule
